// ===== hw/rtl/pss_pkg.sv =====
// Shared types and constants for the positional sequence store.
package pss_pkg;

  localparam int POS_W       = 11;
  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 11;
  // Wide enough for any cell index at the largest supported capacity (4096).
  localparam int AT_W        = 12;

  typedef enum logic [2:0] {
    CMD_APPEND     = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT_AT  = 3'd4,
    CMD_ERASE_AT   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_APPLY
  } state_t;

  typedef struct packed {
    cmd_t                     command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [COUNT_OUT_W-1:0]   entry_count;
    status_t                  status;
  } out_word_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [AT_W-1:0]   at;
    logic [DATA_W-1:0] data;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/pss_cell.sv =====
// One storage cell of the chain: holds one entry and shifts with its neighbors.
module pss_cell
  import pss_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              shift_en,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output logic [DATA_W-1:0] value,
  output logic [DATA_W-1:0] hit_value
);

  localparam logic [AT_W-1:0] Idx = AT_W'(INDEX);

  logic              hit;
  logic              above;
  logic [DATA_W-1:0] value_next;

  assign hit       = (ctl.at == Idx);
  assign above     = (Idx > ctl.at);
  assign hit_value = hit ? value : '0;

  always_comb begin
    value_next = value;
    if (shift_en && ctl.ins) begin
      if (above) begin
        value_next = left;
      end else if (hit) begin
        value_next = ctl.data;
      end
    end else if (shift_en && ctl.rem) begin
      if (above || hit) begin
        value_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== hw/rtl/positional_sequence_store.sv =====
// Top level of the positional sequence store: a bounded ordered list of words held in a cell chain.
//
//   channel  direction  handshake           word
//   in       to block   in_valid/in_stall   in_word_t  (command, position, data_in)
//   out      from block out_valid/out_stall out_word_t (data_out, entry_count, status)
//
// Each command runs through accept, read and apply in turn. The read
// cycle picks the addressed cell through a registered OR tree (groups of 64 cells,
// then one OR over the group results); the apply cycle shifts the chain and updates
// the count, so one command runs at a time.
// Reset clears the count and the handshake state only; cell contents stay undefined
// and are never read before they are written. No clearing pass is needed.
// A stall on out holds the apply step until the output register frees up.
module positional_sequence_store
  import pss_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int XW     = (CW > AT_W) ? CW : AT_W;
  localparam int GROUP  = 64;
  localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;
  localparam int NPAD   = NGROUP * GROUP;

  state_t state;
  state_t state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  cell_ctl_t op;
  cell_ctl_t op_next;
  status_t   op_status;
  status_t   op_status_next;

  logic accept;
  logic read_en;
  logic apply_fire;

  logic [XW-1:0] count_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] at_x;

  logic [DATA_W-1:0] cell_value [CAPACITY];
  logic [DATA_W-1:0] hit_all    [NPAD];
  logic [DATA_W-1:0] grp_or_c   [NGROUP];
  logic [DATA_W-1:0] grp_or     [NGROUP];
  logic [DATA_W-1:0] removed;

  assign accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Decode the command against the current count: pick the position, flag
  // full, empty and out-of-range cases, and latch the operation for the chain.
  // ---------------------------------------------------------------------------
  assign count_x = XW'(count);
  assign pos_x   = XW'(in_data.position);

  always_comb begin
    op_next        = '0;
    op_next.data   = in_data.data_in;
    op_status_next = ST_OK;
    at_x           = '0;
    case (in_data.command)
      CMD_APPEND, CMD_PUSH_FRONT, CMD_INSERT_AT: begin
        at_x = (in_data.command == CMD_APPEND)     ? count_x :
               (in_data.command == CMD_PUSH_FRONT) ? '0 : pos_x;
        if (count_x >= XW'(CAPACITY)) begin
          op_status_next = ST_FULL;
        end else if (at_x > count_x) begin
          op_status_next = ST_RANGE;
        end else begin
          op_next.ins = 1'b1;
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT, CMD_ERASE_AT: begin
        if (count_x == '0) begin
          op_status_next = ST_EMPTY;
        end else begin
          at_x = (in_data.command == CMD_POP_BACK)  ? count_x - XW'(1) :
                 (in_data.command == CMD_POP_FRONT) ? '0 : pos_x;
          if (at_x >= count_x) begin
            op_status_next = ST_RANGE;
          end else begin
            op_next.rem = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    op_next.at = AT_W'(at_x);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= op_next;
      op_status <= op_status_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: accept, read the addressed cell, then apply the shift.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    read_en    = 1'b0;
    apply_fire = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_READ: begin
        read_en = 1'b1;
      end
      S_APPLY: begin
        apply_fire = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: each cell hands its word to the next one on insert and to the
  // previous one on removal. The ends see zero from outside.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_value[i+1];
    end

    pss_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (op),
      .shift_en (apply_fire),
      .left     (left_w),
      .right    (right_w),
      .value    (cell_value[i]),
      .hit_value(hit_all[i])
    );
  end

  // Pad the tree inputs past the last cell.
  for (genvar i = CAPACITY; i < NPAD; i++) begin : g_pad
    assign hit_all[i] = '0;
  end

  // ---------------------------------------------------------------------------
  // Read tree: only the addressed cell drives a nonzero word. OR each group in
  // the read cycle, register, then OR the group results in the apply cycle.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_or_c[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        grp_or_c[g] = grp_or_c[g] | hit_all[g*GROUP + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (read_en) begin
      for (int g = 0; g < NGROUP; g++) begin
        grp_or[g] <= grp_or_c[g];
      end
    end
  end

  always_comb begin
    removed = '0;
    for (int g = 0; g < NGROUP; g++) begin
      removed = removed | grp_or[g];
    end
  end

  // ---------------------------------------------------------------------------
  // Count and output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + CW'(1);
    end else if (op.rem) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_fire) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_fire) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      out_data.data_out    <= op.rem ? removed : '0;
      out_data.entry_count <= COUNT_OUT_W'(count_next);
      out_data.status      <= op_status;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.data_out == '0)
    else $error("failed command returned a nonzero word");

  a_count_out : assert property (@(posedge clk) disable iff (rst)
    apply_fire |=> out_valid && out_data.entry_count == COUNT_OUT_W'(count))
    else $error("reported count differs from stored count");

  a_accept_read : assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ)
    else $error("accepted command did not enter the read cycle");

  a_one_op : assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !(op.ins && op.rem))
    else $error("insert and removal latched together");

endmodule
